>>> src/svalloc_pkg.sv
// Shared types and constants for the voice allocator.
// No dependencies; every other file imports this package.
package svalloc_pkg;

  localparam int NUM_VOICES = 16;
  // Lane index width; at least one bit so a single-voice pool still has a port.
  localparam int VW = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;
  // Counts run from 0 to NUM_VOICES inclusive.
  localparam int CW = $clog2(NUM_VOICES + 1);

  localparam int NOTE_W      = 7;
  localparam int VOICE_OUT_W = 4;
  localparam int STATUS_W    = 2;

  // Event queue between the front and back parts.
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  typedef enum logic {
    OP_PLAY = 1'b0,
    OP_STOP = 1'b1
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_ASSIGNED  = 2'd0,
    ST_STOPPED   = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  typedef struct packed {
    op_t               op;
    logic [NOTE_W-1:0] note;
  } ev_t;

  // Pool occupancy, visible to the top level for checking.
  typedef struct packed {
    logic [CW-1:0] act_cnt;
    logic [CW-1:0] free_cnt;
  } mon_t;

endpackage

>>> src/svalloc_front.sv
// Front part: accepts note events, decodes the command and buffers them
// in a two-entry queue. Depends on svalloc_pkg.
module svalloc_front
  import svalloc_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic              cmd,
  input  logic [NOTE_W-1:0] note,
  output logic              q_valid,
  output ev_t               q_item,
  input  logic              q_pop
);

  ev_t               q [QDEPTH];
  logic [QPTR_W-1:0] wp;
  logic [QPTR_W-1:0] rp;
  logic [QCNT_W-1:0] cnt;
  logic              push;
  ev_t               ev_in;

  assign in_stall = (cnt == QCNT_W'(QDEPTH));
  assign push     = in_valid && !in_stall;
  assign q_valid  = (cnt != '0);
  assign q_item   = q[rp];

  always_comb begin
    ev_in.op   = op_t'(cmd);
    ev_in.note = note;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        wp <= wp + 1'b1;
      end
      if (q_pop) begin
        rp <= rp + 1'b1;
      end
      case ({push, q_pop})
        2'b10:   cnt <= cnt + 1'b1;
        2'b01:   cnt <= cnt - 1'b1;
        default: cnt <= cnt;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q[wp] <= ev_in;
    end
  end

endmodule

>>> src/svalloc_back.sv
// Back part: per-voice lanes with queue rank, one lane scanned per cycle,
// then an update state that, once the output can take a result, shifts ranks and writes the result register.
// Depends on svalloc_pkg.
module svalloc_back
  import svalloc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   q_valid,
  input  ev_t                    q_item,
  output logic                   q_pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [STATUS_W-1:0]    status,
  output logic [VOICE_OUT_W-1:0] voice,
  output logic [NOTE_W-1:0]      played_note,
  output mon_t                   mon
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_APPLY
  } state_t;

  state_t            state;
  logic              act  [NUM_VOICES];
  logic [VW-1:0]     ord  [NUM_VOICES];
  logic [NOTE_W-1:0] vnote[NUM_VOICES];
  logic [CW-1:0]     act_cnt;
  logic [CW-1:0]     free_cnt;
  logic [VW-1:0]     idx;
  logic              found;
  logic [VW-1:0]     best_v;
  logic [VW-1:0]     best_o;
  op_t               cur_op;
  logic [NOTE_W-1:0] cur_note;

  logic              steal;
  logic              hit;
  logic              out_ready;

  assign steal     = (free_cnt == '0);
  assign out_ready = !out_valid || !out_stall;
  assign q_pop     = (state == S_IDLE) && q_valid;
  assign mon.act_cnt  = act_cnt;
  assign mon.free_cnt = free_cnt;

  // Play: the head of the free queue, or of the active queue when none is free.
  // Stop: the matching active voice with the highest rank, i.e. the newest.
  always_comb begin
    if (cur_op == OP_PLAY) begin
      hit = (act[idx] == steal) && (ord[idx] == '0);
    end else begin
      hit = act[idx] && (vnote[idx] == cur_note) && (!found || (ord[idx] > best_o));
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      act_cnt   <= '0;
      free_cnt  <= CW'(NUM_VOICES);
      out_valid <= 1'b0;
      idx       <= '0;
      found     <= 1'b0;
      for (int l = 0; l < NUM_VOICES; l++) begin
        act[l] <= 1'b0;
        ord[l] <= VW'(l);
      end
    end else begin
      // the update cycle sets or holds the result itself
      if (out_valid && !out_stall && (state != S_APPLY)) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            cur_op   <= q_item.op;
            cur_note <= q_item.note;
            idx      <= '0;
            found    <= 1'b0;
            state    <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (hit) begin
            found  <= 1'b1;
            best_v <= idx;
            best_o <= ord[idx];
          end
          if (idx == VW'(NUM_VOICES - 1)) begin
            state <= S_APPLY;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_APPLY: begin
          if (out_ready) begin
            out_valid   <= 1'b1;
            played_note <= cur_note;
            if (cur_op == OP_PLAY) begin
              status <= ST_ASSIGNED;
              voice  <= VOICE_OUT_W'(best_v);
              for (int l = 0; l < NUM_VOICES; l++) begin
                if (VW'(l) == best_v) begin
                  act[l] <= 1'b1;
                  ord[l] <= steal ? VW'(NUM_VOICES - 1) : act_cnt[VW-1:0];
                end else if (act[l] == steal) begin
                  ord[l] <= ord[l] - 1'b1;
                end
              end
              if (!steal) begin
                free_cnt <= free_cnt - 1'b1;
                act_cnt  <= act_cnt + 1'b1;
              end
            end else if (found) begin
              status <= ST_STOPPED;
              voice  <= VOICE_OUT_W'(best_v);
              for (int l = 0; l < NUM_VOICES; l++) begin
                if (VW'(l) == best_v) begin
                  act[l] <= 1'b0;
                  ord[l] <= free_cnt[VW-1:0];
                end else if (act[l] && (ord[l] > best_o)) begin
                  ord[l] <= ord[l] - 1'b1;
                end
              end
              free_cnt <= free_cnt + 1'b1;
              act_cnt  <= act_cnt - 1'b1;
            end else begin
              status <= ST_NOT_FOUND;
              voice  <= '0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Note tags are payload: written on play, never cleared.
  always_ff @(posedge clk) begin
    if ((state == S_APPLY) && out_ready && (cur_op == OP_PLAY)) begin
      for (int l = 0; l < NUM_VOICES; l++) begin
        if (VW'(l) == best_v) begin
          vnote[l] <= cur_note;
        end
      end
    end
  end

endmodule

>>> src/synth_voice_allocator.sv
// Voice allocator: play takes the longest-free voice or steals the oldest
// active one; stop frees the newest active voice holding the note.
// Each item is taken from the queue, scanned one lane per cycle, then applied;
// the back part finishes one item before it takes the next from the queue.
// Reset: all voices free, oldest-free order 0..NUM_VOICES-1, queue empty;
// note tags are not cleared. Depends on svalloc_pkg, svalloc_front, svalloc_back.
module synth_voice_allocator
  import svalloc_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic                   cmd,
  input  logic [NOTE_W-1:0]      note,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic [STATUS_W-1:0]    status,
  output logic [VOICE_OUT_W-1:0] voice,
  output logic [NOTE_W-1:0]      played_note
);

  logic q_valid;
  ev_t  q_item;
  logic q_pop;
  mon_t mon;

  svalloc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .cmd      (cmd),
    .note     (note),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  svalloc_back u_back (
    .clk         (clk),
    .rst         (rst),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .status      (status),
    .voice       (voice),
    .played_note (played_note),
    .mon         (mon)
  );

  // Every voice sits in exactly one of the two queues.
  a_pool_total: assert property (@(posedge clk) disable iff (rst)
    (32'(mon.act_cnt) + 32'(mon.free_cnt)) == NUM_VOICES)
    else $error("voice pool count mismatch");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_ASSIGNED || status == ST_STOPPED
                   || status == ST_NOT_FOUND))
    else $error("bad status code");

  a_not_found_voice: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_NOT_FOUND) |-> (voice == '0))
    else $error("not-found result carries a voice");

  // A play always lands on a voice, so the active queue cannot be empty after it.
  a_play_active: assert property (@(posedge clk) disable iff (rst)
    (out_valid && status == ST_ASSIGNED) |-> (mon.act_cnt != '0))
    else $error("assigned voice missing from active queue");

endmodule

>>> test/synth_voice_allocator_tb.sv
// Testbench for synth_voice_allocator: random and directed play/stop items with
// a queue-based model of the free and active voice orders. Depends on svalloc_pkg.
module synth_voice_allocator_tb;
  import svalloc_pkg::*;

  typedef struct packed {
    status_t                status;
    logic [VOICE_OUT_W-1:0] voice;
    logic [NOTE_W-1:0]      note;
  } alloc_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic                   cmd = 1'b0;
  logic [NOTE_W-1:0]      note = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [STATUS_W-1:0]    status;
  logic [VOICE_OUT_W-1:0] voice;
  logic [NOTE_W-1:0]      played_note;

  ev_t           pending_events[$];
  alloc_result_t expected_results[$];
  ev_t           next_event;
  int            send_idle_pct = 0;
  int            recv_idle_pct = 0;
  int            mismatches = 0;

  // Allocator model: voice tags plus the two orderings, oldest at the front.
  logic [NOTE_W-1:0] voice_tag[NUM_VOICES];
  int                active_voices[$];
  int                free_voices[$];

  synth_voice_allocator DUT (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .cmd(cmd), .note(note),
    .out_valid(out_valid), .out_stall(out_stall),
    .status(status), .voice(voice), .played_note(played_note)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic void allocate_voice(input op_t op, input logic [NOTE_W-1:0] n);
    alloc_result_t r;
    int            v;
    int            pos;
    r.note   = n;
    r.voice  = '0;
    r.status = ST_NOT_FOUND;
    if (op == OP_PLAY) begin
      // take the longest-free voice, else steal the oldest active one
      if (free_voices.size() > 0) v = free_voices.pop_front();
      else v = active_voices.pop_front();
      voice_tag[v] = n;
      active_voices.push_back(v);
      r.status = ST_ASSIGNED;
      r.voice  = VOICE_OUT_W'(v);
    end else begin
      pos = -1;
      for (int i = active_voices.size() - 1; i >= 0; i--) begin
        if (pos < 0 && voice_tag[active_voices[i]] == n) pos = i;
      end
      if (pos >= 0) begin
        v = active_voices[pos];
        active_voices.delete(pos);
        free_voices.push_back(v);
        r.status = ST_STOPPED;
        r.voice  = VOICE_OUT_W'(v);
      end
    end
    expected_results.push_back(r);
  endfunction

  // Driver: advance to the next pending item when the current one is taken.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) allocate_voice(op_t'(cmd), note);
      if (!in_valid || !in_stall) begin
        if (pending_events.size() > 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          next_event = pending_events.pop_front();
          in_valid <= 1'b1;
          cmd      <= next_event.op;
          note     <= next_event.note;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted result with the oldest expectation.
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result status=%0d voice=%0d note=%0d",
                   $time, status, voice, played_note);
          mismatches++;
        end else begin
          alloc_result_t exp_r;
          exp_r = expected_results.pop_front();
          if (status !== exp_r.status) begin
            $display("%0t: status expected %0d actual %0d", $time, exp_r.status, status);
            mismatches++;
          end
          if (voice !== exp_r.voice) begin
            $display("%0t: voice expected %0d actual %0d", $time, exp_r.voice, voice);
            mismatches++;
          end
          if (played_note !== exp_r.note) begin
            $display("%0t: played_note expected %0d actual %0d",
                     $time, exp_r.note, played_note);
            mismatches++;
          end
        end
      end
      out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end
  end

  task automatic push_event(input op_t op, input logic [NOTE_W-1:0] n);
    ev_t e;
    e.op   = op;
    e.note = n;
    pending_events.push_back(e);
  endtask

  // Notes mostly come from a narrow band so that stops hit and notes repeat.
  task automatic push_random(input int count, input int play_pct);
    logic [NOTE_W-1:0] n;
    for (int i = 0; i < count; i++) begin
      if ($urandom_range(0, 99) < 75) n = NOTE_W'($urandom_range(60, 71));
      else n = NOTE_W'($urandom_range(0, 127));
      push_event(($urandom_range(0, 99) < play_pct) ? OP_PLAY : OP_STOP, n);
    end
  endtask

  // Check away from the rising edge so driver and monitor updates have settled.
  task automatic wait_drained;
    while (pending_events.size() != 0 || in_valid || expected_results.size() != 0)
      @(negedge clk);
  endtask

  initial begin
    for (int i = 0; i < NUM_VOICES; i++) free_voices.push_back(i);
    send_idle_pct = 28;
    recv_idle_pct = 83;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // stop with nothing playing, note extremes, duplicate notes
    push_event(OP_STOP, 7'd5);
    push_event(OP_PLAY, 7'd0);
    push_event(OP_PLAY, 7'd127);
    push_event(OP_PLAY, 7'd127);
    push_event(OP_STOP, 7'd127);
    push_event(OP_STOP, 7'd127);
    push_event(OP_STOP, 7'd127);
    push_event(OP_STOP, 7'd0);
    // fill the pool, then steal the two oldest voices
    for (int k = 0; k < NUM_VOICES + 2; k++) push_event(OP_PLAY, NOTE_W'(k * 8 + 3));
    push_random(320, 65);
    wait_drained();

    send_idle_pct = 83;
    recv_idle_pct = 28;
    push_random(330, 40);
    wait_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    push_random(330, 55);
    wait_drained();

    repeat (40) @(posedge clk);
    if (mismatches == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

>>> filelist.f
src/svalloc_pkg.sv
src/svalloc_front.sv
src/svalloc_back.sv
src/synth_voice_allocator.sv
test/synth_voice_allocator_tb.sv
